FILE: design/mcps_pkg.sv
// Shared constants, codes and types of the multi-channel poll scheduler.
// No dependencies; every design file imports it.
`default_nettype none

package mcps_pkg;

   localparam int MAX_CHANNELS  = 256;
   localparam int MAX_PERIOD_MS = 2000;
   localparam int MIN_PERIOD_MS = 100;

   localparam int CH_W    = $clog2(MAX_CHANNELS);
   localparam int CNT_W   = $clog2(MAX_CHANNELS + 1);
   localparam int CFG_W   = 9;
   localparam int PER_W   = 11;
   localparam int VAL_W   = 16;
   localparam int TIME_W  = 32;
   localparam int CHAN_W  = 8;
   localparam int AMT_W   = 16;
   localparam int OP_W    = 2;
   localparam int STAT_W  = 2;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [OP_W-1:0] {
      OP_TICK       = 2'd0,
      OP_SET_PERIOD = 2'd1,
      OP_SET_COUNT  = 2'd2,
      OP_READ       = 2'd3
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE       = 2'd0,
      ST_NO_CHANNEL = 2'd1,
      ST_REJECT     = 2'd2
   } status_type;

   typedef struct packed {
      logic [PER_W-1:0]        period;
      logic signed [VAL_W-1:0] value;
      logic [TIME_W-1:0]       stamp;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      period: PER_W'(MAX_PERIOD_MS),
      value:  '0,
      stamp:  '0
   };

   // controller -> datapath
   typedef struct packed {
      logic accept;    // latch request fields
      logic check;     // decide status, start the table walk
      logic load_rsp;  // load the response register
   } dp_cmd_type;

endpackage

`default_nettype wire

FILE: design/multi_channel_poll_scheduler_unit.sv
// Table entries walked per transaction:
// tick and set period walk active_count entries, read walks 1, a count increase
// walks the added entries, a shrink, a rejected item or a failed item walks none.
// One transaction is in work at a time; the walk runs through the single table
// port (one entry read and one written per cycle), and a waiting result stalls the next.
// Reset is synchronous, active high: one active channel, all entries at reset value via valid bits.
`default_nettype none

module multi_channel_poll_scheduler_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [mcps_pkg::CFG_W-1:0]      csr_wr_data,   // start_channel_count
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // now_ms[31:0], sample[47:32], channel[55:48], amount[71:56]
   input  wire logic [mcps_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic [mcps_pkg::OP_W-1:0]       req_tuser,     // opcode[1:0]
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // read_value[15:0], updated_count[24:16], min_period[35:25],
   // channel_count[44:36], zero[47:45]
   output logic [mcps_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [mcps_pkg::STAT_W-1:0]          rsp_tuser      // status[1:0]
);
   import mcps_pkg::*;

   dp_cmd_type cmd;
   logic       busy;

   mcps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .busy       (busy),
      .cmd        (cmd)
   );

   mcps_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .cmd         (cmd),
      .busy        (busy),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

`default_nettype wire

FILE: design/mcps_ctrl.sv
// Sequencing FSM of the poll scheduler: input handshake, table walk wait,
// response handshake. Depends on mcps_pkg.
`default_nettype none

module mcps_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire logic                busy,
   output mcps_pkg::dp_cmd_type     cmd
);
   import mcps_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_SWEEP,
      S_RESPOND
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      rsp_valid_ff;
   logic      accept;
   logic      slot_free;

   assign accept    = req_tvalid & ready_ff;
   assign slot_free = ~rsp_valid_ff | rsp_tready;

   assign req_tready = ready_ff;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd.accept   = accept;
      cmd.check    = (state_ff == S_CHECK);
      cmd.load_rsp = (state_ff == S_RESPOND) & slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ready_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  ready_ff <= 1'b0;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               state_ff <= S_SWEEP;
            end
            S_SWEEP: begin
               if (!busy) begin
                  state_ff <= S_RESPOND;
               end
            end
            S_RESPOND: begin
               // a waiting result must be taken before the new one lands
               if (slot_free) begin
                  ready_ff     <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: design/mcps_datapath.sv
// Datapath of the poll scheduler: request latch, channel table memory with
// per-entry valid bits, table walk engine and response register. Uses mcps_pkg.
`default_nettype none

module mcps_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [mcps_pkg::CFG_W-1:0]        csr_wr_data,
   input  wire logic [mcps_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic [mcps_pkg::OP_W-1:0]         req_tuser,
   input  wire mcps_pkg::dp_cmd_type              cmd,
   output logic                                   busy,
   output logic [mcps_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic [mcps_pkg::STAT_W-1:0]            rsp_tuser
);
   import mcps_pkg::*;

   typedef enum logic [1:0] {
      M_TICK,
      M_MIN,
      M_READ,
      M_GROW
   } mode_type;

   // request latch
   opcode_type              op_ff,     op_in;
   logic [TIME_W-1:0]       now_ff,    now_in;
   logic signed [VAL_W-1:0] sample_ff, sample_in;
   logic [CHAN_W-1:0]       chan_ff,   chan_in;
   logic [AMT_W-1:0]        amount_ff, amount_in;
   status_type              status_ff, status_in;

   // scheduler state
   logic [CNT_W-1:0]        active_ff,   active_in;
   logic [PER_W-1:0]        smallest_ff, smallest_in;
   logic [MAX_CHANNELS-1:0] valid_ff,    valid_in;

   // walk engine
   logic                    run_ff,      run_in;
   logic [CNT_W-1:0]        idx_ff,      idx_in;
   logic [CNT_W-1:0]        end_ff,      end_in;
   mode_type                mode_ff,     mode_in;
   logic                    pipe_vld_ff, pipe_vld_in;
   logic [CH_W-1:0]         pipe_idx_ff, pipe_idx_in;
   logic [CNT_W-1:0]        upd_ff,      upd_in;
   logic signed [VAL_W-1:0] rd_val_ff,   rd_val_in;

   // memory
   entry_type               chan_mem_ff [MAX_CHANNELS];
   entry_type               rd_ent_ff;
   logic                    rd_vld_ff;
   logic [CH_W-1:0]         rd_addr;
   logic                    wr_en;
   logic [CH_W-1:0]         wr_addr;
   entry_type               wr_ent;

   // response register
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [STAT_W-1:0]       rsp_user_ff, rsp_user_in;

   // decode helpers
   logic [CNT_W-1:0]        n_clamp;
   logic [PER_W-1:0]        p_clamp;
   logic [CNT_W-1:0]        csr_clamp;
   logic [CH_W-1:0]         chan_addr;
   logic                    ch_ok;
   status_type              status_comb;
   entry_type               ent;
   logic [TIME_W-1:0]       elapsed;
   logic                    due;
   logic                    is_ch;
   logic [PER_W-1:0]        new_per;
   logic [VAL_W-1:0]        rsp_value;
   logic [CNT_W-1:0]        rsp_upd;

   assign n_clamp = (amount_ff > AMT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS)
                                                       : CNT_W'(amount_ff);
   assign p_clamp = (amount_ff < AMT_W'(MIN_PERIOD_MS)) ? PER_W'(MIN_PERIOD_MS) :
                    (amount_ff > AMT_W'(MAX_PERIOD_MS)) ? PER_W'(MAX_PERIOD_MS) :
                    amount_ff[PER_W-1:0];
   assign csr_clamp = (csr_wr_data == '0) ? CNT_W'(1) :
                      (32'(csr_wr_data) > 32'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) :
                      CNT_W'(csr_wr_data);
   assign chan_addr = CH_W'(chan_ff);
   assign ch_ok     = (32'(chan_ff) < 32'(active_ff));

   always_comb begin
      case (op_ff)
         OP_TICK:       status_comb = ST_DONE;
         OP_SET_PERIOD: status_comb = ch_ok ? ST_DONE : ST_NO_CHANNEL;
         OP_SET_COUNT:  status_comb = ((n_clamp == active_ff) || (n_clamp == '0)) ?
                                      ST_REJECT : ST_DONE;
         OP_READ:       status_comb = ch_ok ? ST_DONE : ST_NO_CHANNEL;
         default:       status_comb = ST_DONE;
      endcase
   end

   // entry seen by the process stage; never-written entries read as reset
   assign ent     = rd_vld_ff ? rd_ent_ff : ENTRY_RESET;
   assign elapsed = now_ff - ent.stamp;
   assign due     = (elapsed >= TIME_W'(ent.period));
   assign is_ch   = (pipe_idx_ff == chan_addr);
   assign new_per = is_ch ? p_clamp : ent.period;
   assign rd_addr = idx_ff[CH_W-1:0];
   assign busy    = run_ff | pipe_vld_ff;

   always_comb begin
      op_in       = op_ff;
      now_in      = now_ff;
      sample_in   = sample_ff;
      chan_in     = chan_ff;
      amount_in   = amount_ff;
      status_in   = status_ff;
      active_in   = active_ff;
      smallest_in = smallest_ff;
      valid_in    = valid_ff;
      run_in      = run_ff;
      idx_in      = idx_ff;
      end_in      = end_ff;
      mode_in     = mode_ff;
      pipe_vld_in = 1'b0;
      pipe_idx_in = pipe_idx_ff;
      upd_in      = upd_ff;
      rd_val_in   = rd_val_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      wr_en       = 1'b0;
      wr_addr     = pipe_idx_ff;
      wr_ent      = ent;

      if (cmd.accept) begin
         op_in     = opcode_type'(req_tuser);
         now_in    = req_tdata[31:0];
         sample_in = req_tdata[47:32];
         chan_in   = req_tdata[55:48];
         amount_in = req_tdata[71:56];
         upd_in    = '0;
      end

      if (cmd.check) begin
         status_in = status_comb;
         if (status_comb == ST_DONE) begin
            case (op_ff)
               OP_TICK: begin
                  run_in  = 1'b1;
                  idx_in  = '0;
                  end_in  = active_ff;
                  mode_in = M_TICK;
               end
               OP_SET_PERIOD: begin
                  run_in      = 1'b1;
                  idx_in      = '0;
                  end_in      = active_ff;
                  mode_in     = M_MIN;
                  smallest_in = PER_W'(MAX_PERIOD_MS);
               end
               OP_READ: begin
                  run_in  = 1'b1;
                  idx_in  = CNT_W'(chan_ff);
                  end_in  = CNT_W'(chan_ff) + CNT_W'(1);
                  mode_in = M_READ;
               end
               OP_SET_COUNT: begin
                  active_in = n_clamp;
                  if (n_clamp > active_ff) begin
                     run_in  = 1'b1;
                     idx_in  = active_ff;
                     end_in  = n_clamp;
                     mode_in = M_GROW;
                  end
               end
               default: begin
                  run_in = 1'b0;
               end
            endcase
         end
      end

      // issue stage: one table read per cycle
      if (run_ff) begin
         pipe_vld_in = 1'b1;
         pipe_idx_in = idx_ff[CH_W-1:0];
         idx_in      = idx_ff + CNT_W'(1);
         run_in      = ((idx_ff + CNT_W'(1)) != end_ff);
      end

      // process stage: act on the entry read last cycle
      if (pipe_vld_ff) begin
         case (mode_ff)
            M_TICK: begin
               if (due) begin
                  wr_en  = 1'b1;
                  wr_ent = '{period: ent.period, value: sample_ff, stamp: now_ff};
                  upd_in = upd_ff + CNT_W'(1);
               end
            end
            M_MIN: begin
               if (is_ch) begin
                  wr_en  = 1'b1;
                  wr_ent = '{period: p_clamp, value: ent.value, stamp: ent.stamp};
               end
               if (new_per < smallest_ff) begin
                  smallest_in = new_per;
               end
            end
            M_READ: begin
               rd_val_in = ent.value;
            end
            M_GROW: begin
               wr_en  = 1'b1;
               wr_ent = '{period: PER_W'(MAX_PERIOD_MS), value: '0, stamp: now_ff};
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end

      if (cmd.load_rsp) begin
         rsp_data_in = {3'b000, 9'(active_ff), smallest_ff, 9'(rsp_upd), rsp_value};
         rsp_user_in = status_ff;
      end

      // reload of the table: every entry back to its reset value
      if (csr_wr_en) begin
         active_in   = csr_clamp;
         smallest_in = PER_W'(MAX_PERIOD_MS);
         valid_in    = '0;
      end
   end

   assign rsp_value = ((op_ff == OP_READ) && (status_ff == ST_DONE)) ? rd_val_ff : '0;
   assign rsp_upd   = (op_ff == OP_TICK) ? upd_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= CNT_W'(1);
         smallest_ff <= PER_W'(MAX_PERIOD_MS);
         valid_ff    <= '0;
         run_ff      <= 1'b0;
         pipe_vld_ff <= 1'b0;
      end else begin
         active_ff   <= active_in;
         smallest_ff <= smallest_in;
         valid_ff    <= valid_in;
         run_ff      <= run_in;
         pipe_vld_ff <= pipe_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      now_ff      <= now_in;
      sample_ff   <= sample_in;
      chan_ff     <= chan_in;
      amount_ff   <= amount_in;
      status_ff   <= status_in;
      idx_ff      <= idx_in;
      end_ff      <= end_in;
      mode_ff     <= mode_in;
      pipe_idx_ff <= pipe_idx_in;
      upd_ff      <= upd_in;
      rd_val_ff   <= rd_val_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         chan_mem_ff[wr_addr] <= wr_ent;
      end
      rd_ent_ff <= chan_mem_ff[rd_addr];
      rd_vld_ff <= valid_ff[rd_addr];
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

`default_nettype wire

FILE: design/mcps_checker.sv
// Port-level checks of the poll scheduler top, attached by bind.
// Depends on mcps_pkg and multi_channel_poll_scheduler_unit.
`default_nettype none

module mcps_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [mcps_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [mcps_pkg::STAT_W-1:0]     rsp_tuser
);
   import mcps_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // one transaction in work at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while a transaction is in work");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad handshake state after reset");

   // a failed item reports no read value and no updates
   a_fail_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_DONE) |->
         (rsp_tdata[15:0] == 16'd0) && (rsp_tdata[24:16] == 9'd0))
      else $error("failed transaction carries data");

endmodule

bind multi_channel_poll_scheduler_unit mcps_checker u_mcps_checker (.*);

`default_nettype wire
